@@ hdl/brp_pkg.sv @@
// ----------------------------------------------------------------------------
// BMP pixel row unpacker package
// Shared item types, register indexes and pixel constants.
// ----------------------------------------------------------------------------
`default_nettype none

package brp_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHROMA_KEY  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd2;

   localparam logic [1:0] MODE_PAL8  = 2'd0;
   localparam logic [1:0] MODE_RGB16 = 2'd1;
   localparam logic [1:0] MODE_BGR24 = 2'd2;
   localparam logic [1:0] MODE_BGR32 = 2'd3;

   localparam logic       FUNC_PALETTE = 1'b0;
   localparam logic       FUNC_PIXEL   = 1'b1;

   localparam logic [23:0] KEY_TOLERANCE = 24'hfefefe;
   localparam logic [31:0] ALPHA_CLEAR   = 32'hfc000000;
   localparam logic [31:0] ALPHA_OPAQUE  = 32'hff000000;

   localparam logic [1:0]  RESET_MODE  = MODE_BGR32;
   localparam logic [12:0] RESET_WIDTH = 13'd1;

   typedef struct packed {
      logic        func;
      logic [7:0]  palette_index;
      logic [31:0] palette_word;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_argb;
      logic        row_last;
   } rsp_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0]  pixel_mode;
      logic [23:0] chroma_key;
      logic [12:0] image_width;
      logic        row_restart;
   } cfg_type;

   // Palette memory access issued when an item is accepted.
   typedef struct packed {
      logic        wr_en;
      logic [7:0]  wr_index;
      logic [31:0] wr_data;
      logic        rd_en;
      logic [7:0]  rd_index;
   } pal_req_type;

   // Item held between the input side and the result register.
   typedef struct packed {
      logic        valid;
      logic        use_palette;
      logic        palette_miss;
      logic [31:0] pixel;
      logic        row_last;
   } stage_type;

endpackage

`default_nettype wire

@@ hdl/bmp_pixel_row_unpacker.sv @@
// A completing byte is registered in the held stage, then in the result register.
// Throughput: one item per cycle when not stalled; the palette RAM read port and
// the held stage plus result register let a byte enter every cycle while results
// flow out. Palette loads and row padding bytes produce no result.
// Reset (synchronous): row state clears, pixel_mode=3, chroma_key=0,
// image_width=1; palette contents stay undefined until written.
// ----------------------------------------------------------------------------
// BMP pixel row unpacker
// Converts a BMP pixel byte stream to ARGB8888 pixels with row-end flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_row_unpacker #(
   parameter int MAX_WIDTH       = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire brp_pkg::req_type                   req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output brp_pkg::rsp_type                        rsp_payload,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [brp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [brp_pkg::CSR_DATA_W-1:0]     csr_data
);

   import brp_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic [1:0]  mode_ff;
   logic [23:0] key_ff;
   logic [12:0] width_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   cfg_type     cfg;
   pal_req_type pal_req;
   stage_type   stage;
   logic        csr_wr;
   logic        stage_take;
   logic        accept;
   logic [31:0] pal_rdata;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= RESET_MODE;
         key_ff   <= '0;
         width_ff <= RESET_WIDTH;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_PIXEL_MODE:  mode_ff  <= csr_data[1:0];
            CSR_CHROMA_KEY:  key_ff   <= csr_data;
            CSR_IMAGE_WIDTH: width_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pixel_mode  = mode_ff;
      cfg.chroma_key  = key_ff;
      cfg.image_width = width_ff;
      cfg.row_restart = csr_wr &&
                        (csr_index == CSR_PIXEL_MODE || csr_index == CSR_IMAGE_WIDTH);
   end

   // The held stage moves on when the result register is empty or draining.
   assign stage_take = stage.valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage.valid && !stage_take;
   assign accept     = req_valid && !req_stall;

   brp_front #(
      .MAX_WIDTH       (MAX_WIDTH),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .req        (req_payload),
      .stage_take (stage_take),
      .pal_req    (pal_req),
      .stage      (stage)
   );

   brp_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_req.wr_en),
      .wr_addr (pal_req.wr_index[IDX_W-1:0]),
      .wr_data (pal_req.wr_data),
      .rd_en   (pal_req.rd_en),
      .rd_addr (pal_req.rd_index[IDX_W-1:0]),
      .rd_data (pal_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (stage_take) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.row_last = stage.row_last;
         if (stage.use_palette) begin
            rsp_data_in.pixel_argb = stage.palette_miss ? 32'd0 : pal_rdata;
         end else begin
            rsp_data_in.pixel_argb = stage.pixel;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/brp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/brp_front.sv @@
// ----------------------------------------------------------------------------
// BMP unpacker front end
// Row tracking, byte assembly and pixel formatting, resolved at the accept edge
// into one held stage, plus the palette word transform for palette writes.
// ----------------------------------------------------------------------------
`default_nettype none

module brp_front #(
   parameter int MAX_WIDTH       = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire brp_pkg::cfg_type cfg,
   input  wire logic             accept,
   input  wire brp_pkg::req_type req,
   input  wire logic             stage_take,
   output brp_pkg::pal_req_type  pal_req,
   output brp_pkg::stage_type    stage
);

   import brp_pkg::*;

   localparam logic [16:0] MAX_W    = 17'(MAX_WIDTH);
   localparam logic [8:0]  PAL_SIZE = 9'(PALETTE_ENTRIES);

   logic [14:0] pos_ff, pos_in;
   logic [23:0] asm_ff, asm_in;
   logic [1:0]  phase_ff, phase_in;
   logic [12:0] count_ff, count_in;
   stage_type   stage_ff, stage_in;

   logic [12:0] eff_width;
   logic [14:0] width_mul;
   logic [14:0] row_bytes;
   logic [15:0] pos_inc;
   logic [23:0] asm_new;
   logic [12:0] count_inc;
   logic        in_row;
   logic        pixel_done;
   logic        is_pixel;
   logic [31:0] fmt_pixel;
   logic [23:0] key_masked;
   logic        key_hit;
   logic        alpha_hit;

   // Width 0 behaves as 1, anything past the limit as the limit.
   always_comb begin
      if (cfg.image_width == 13'd0) begin
         eff_width = 13'd1;
      end else if ({4'b0, cfg.image_width} > MAX_W) begin
         eff_width = MAX_W[12:0];
      end else begin
         eff_width = cfg.image_width;
      end
   end

   always_comb begin
      case (cfg.pixel_mode)
         MODE_PAL8:  width_mul = {2'b0, eff_width};
         MODE_RGB16: width_mul = {1'b0, eff_width, 1'b0};
         MODE_BGR24: width_mul = {2'b0, eff_width} + {1'b0, eff_width, 1'b0};
         default:    width_mul = {eff_width, 2'b0};
      endcase
   end

   // Rows are padded to a multiple of four bytes.
   assign row_bytes = (width_mul + 15'd3) & ~15'd3;
   assign pos_inc   = {1'b0, pos_ff} + 16'd1;
   assign count_inc = count_ff + 13'd1;
   assign in_row    = count_ff < eff_width;
   assign is_pixel  = req.func == FUNC_PIXEL;

   always_comb begin
      case (phase_ff)
         2'd0:    asm_new = asm_ff | {16'b0, req.data_byte};
         2'd1:    asm_new = asm_ff | {8'b0, req.data_byte, 8'b0};
         2'd2:    asm_new = asm_ff | {req.data_byte, 16'b0};
         default: asm_new = asm_ff;
      endcase
   end

   // A pixel is complete once the phase reaches bytes-per-pixel minus one.
   assign pixel_done = in_row && (phase_ff >= cfg.pixel_mode);

   always_comb begin
      case (cfg.pixel_mode)
         MODE_RGB16: fmt_pixel = {8'hff,
                                  asm_new[14:10], asm_new[14:12],
                                  asm_new[9:5], asm_new[9:7],
                                  asm_new[4:0], asm_new[4:2]};
         MODE_BGR24: begin
            if (cfg.chroma_key != 24'd0 && cfg.chroma_key == asm_new) begin
               fmt_pixel = 32'd0;
            end else begin
               fmt_pixel = {8'h00, asm_new} | ALPHA_OPAQUE;
            end
         end
         default:    fmt_pixel = {8'h00, asm_new} | ALPHA_OPAQUE;
      endcase
   end

   always_comb begin
      pos_in   = pos_ff;
      asm_in   = asm_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      if (cfg.row_restart) begin
         pos_in   = '0;
         asm_in   = '0;
         phase_in = '0;
         count_in = '0;
      end else if (accept && is_pixel) begin
         if (in_row) begin
            if (pixel_done) begin
               asm_in   = '0;
               phase_in = '0;
               count_in = count_inc;
            end else begin
               asm_in   = asm_new;
               phase_in = phase_ff + 2'd1;
            end
         end
         pos_in = pos_inc[14:0];
         if (pos_inc >= {1'b0, row_bytes}) begin
            pos_in   = '0;
            asm_in   = '0;
            phase_in = '0;
            count_in = '0;
         end
      end
   end

   // Palette words are stored already keyed and made opaque.
   assign key_masked = cfg.chroma_key & KEY_TOLERANCE;
   assign key_hit    = key_masked != 24'd0 &&
                       (req.palette_word[23:0] & KEY_TOLERANCE) == key_masked;
   assign alpha_hit  = (req.palette_word & ALPHA_CLEAR) == ALPHA_CLEAR;

   always_comb begin
      pal_req.wr_en    = accept && !is_pixel && ({1'b0, req.palette_index} < PAL_SIZE);
      pal_req.wr_index = req.palette_index;
      pal_req.wr_data  = (key_hit || alpha_hit) ? 32'd0 : (req.palette_word | ALPHA_OPAQUE);
      pal_req.rd_en    = accept && is_pixel && pixel_done && cfg.pixel_mode == MODE_PAL8;
      pal_req.rd_index = asm_new[7:0];
   end

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid        = is_pixel && pixel_done;
         stage_in.use_palette  = cfg.pixel_mode == MODE_PAL8;
         stage_in.palette_miss = {1'b0, asm_new[7:0]} >= PAL_SIZE;
         stage_in.pixel        = fmt_pixel;
         stage_in.row_last     = count_inc >= eff_width;
      end else if (stage_take) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         asm_ff         <= '0;
         phase_ff       <= '0;
         count_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         asm_ff         <= asm_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.use_palette  <= stage_in.use_palette;
      stage_ff.palette_miss <= stage_in.palette_miss;
      stage_ff.pixel        <= stage_in.pixel;
      stage_ff.row_last     <= stage_in.row_last;
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

@@ hdl/brp_checker.sv @@
// ----------------------------------------------------------------------------
// BMP unpacker port checker
// Watches the top-level ports for handshake and flow-control consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module brp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire brp_pkg::rsp_type rsp_payload,
   input wire logic             csr_valid,
   input wire logic             csr_ready
);

   // A held result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // The input side backs up only when a result is waiting downstream.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the result side was free");

   // Coming out of reset nothing is pending and input is open.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Register writes are never refused.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind bmp_pixel_row_unpacker brp_checker u_brp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);

`default_nettype wire
